// File: rtl/sgr_pkg.sv
// ----------------------------------------------------------------------------
// SGR attribute parser package
// Shared types and character constants for the escape-sequence parser.
// ----------------------------------------------------------------------------
package sgr_pkg;

  // Display attribute word, bold in the least significant bit.
  typedef struct packed {
    logic [2:0] bg_color;
    logic       bg_set;
    logic [2:0] fg_color;
    logic       fg_set;
    logic       inverse;
    logic       blink;
    logic       underline;
    logic       bold;
  } attr_t;

  // Parser mode.
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_BRACK = 2'd2,
    MODE_NUM   = 2'd3
  } mode_t;

  // Character codes.
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_ESC     = 8'd27;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_M       = 8'h6D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // SGR codes.
  localparam logic [7:0] SGR_RESET     = 8'd0;
  localparam logic [7:0] SGR_BOLD      = 8'd1;
  localparam logic [7:0] SGR_UNDERLINE = 8'd4;
  localparam logic [7:0] SGR_BLINK     = 8'd5;
  localparam logic [7:0] SGR_INVERSE   = 8'd7;
  localparam logic [7:0] SGR_FG_LO     = 8'd30;
  localparam logic [7:0] SGR_FG_HI     = 8'd37;
  localparam logic [7:0] SGR_BG_LO     = 8'd40;
  localparam logic [7:0] SGR_BG_HI     = 8'd47;

endpackage

// File: rtl/sgr_step.sv
// ----------------------------------------------------------------------------
// SGR parser step
// Next parser mode, accumulator and attribute word for one text byte.
// ----------------------------------------------------------------------------
module sgr_step import sgr_pkg::*; (
  input  mode_t      mode_i,
  input  logic [7:0] acc_i,
  input  attr_t      attr_i,
  input  logic [7:0] byte_i,
  output mode_t      mode_o,
  output logic [7:0] acc_o,
  output attr_t      attr_o
);

  logic       is_digit;
  logic [7:0] digit_val;
  logic [7:0] acc_times10;
  attr_t      applied;

  assign is_digit    = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign digit_val   = byte_i - CH_ZERO;
  // The accumulator wraps at 8 bits: 10x is 8x plus 2x.
  assign acc_times10 = {acc_i[4:0], 3'b000} + {acc_i[6:0], 1'b0};

  // Attribute after applying the code held in the accumulator.
  always_comb begin
    applied = attr_i;
    if (acc_i == SGR_RESET) begin
      applied = '0;
    end else if (acc_i == SGR_BOLD) begin
      applied.bold = 1'b1;
    end else if (acc_i == SGR_UNDERLINE) begin
      applied.underline = 1'b1;
    end else if (acc_i == SGR_BLINK) begin
      applied.blink = 1'b1;
    end else if (acc_i == SGR_INVERSE) begin
      applied.inverse = 1'b1;
    end else if ((acc_i >= SGR_FG_LO) && (acc_i <= SGR_FG_HI)) begin
      applied.fg_set   = 1'b1;
      applied.fg_color = 3'(acc_i - SGR_FG_LO);
    end else if ((acc_i >= SGR_BG_LO) && (acc_i <= SGR_BG_HI)) begin
      applied.bg_set   = 1'b1;
      applied.bg_color = 3'(acc_i - SGR_BG_LO);
    end
  end

  // Parser transition, then the newline rule on the attribute.
  always_comb begin
    mode_o = mode_i;
    acc_o  = acc_i;
    attr_o = attr_i;
    unique case (mode_i)
      MODE_IDLE: begin
        if (byte_i == CH_ESC) mode_o = MODE_ESC;
      end
      MODE_ESC: begin
        mode_o = (byte_i == CH_LBRACK) ? MODE_BRACK : MODE_IDLE;
      end
      MODE_BRACK: begin
        if (byte_i == CH_SEMI) begin
          attr_o = '0;
        end else if (is_digit) begin
          acc_o  = digit_val;
          mode_o = MODE_NUM;
        end else if (byte_i == CH_M) begin
          attr_o = '0;
          mode_o = MODE_IDLE;
        end else begin
          mode_o = MODE_IDLE;
        end
      end
      MODE_NUM: begin
        if (byte_i == CH_SEMI) begin
          attr_o = applied;
          acc_o  = '0;
        end else if (byte_i == CH_M) begin
          attr_o = applied;
          mode_o = MODE_IDLE;
        end else if (is_digit) begin
          acc_o = acc_times10 + digit_val;
        end else begin
          mode_o = MODE_IDLE;
        end
      end
      default: mode_o = MODE_IDLE;
    endcase
    if (byte_i == CH_NEWLINE) attr_o = '0;
  end

endmodule

// File: rtl/ansi_sgr_attribute_parser_unit.sv
// ----------------------------------------------------------------------------
// ANSI SGR attribute parser unit
// Results are registered; one byte is accepted per cycle while in_stall is
// low, and the parser state updates in the accept cycle. A two-entry output
// buffer (result register plus skid register) keeps accepting while one
// result waits; in_stall rises only when both are full.
// Reset (synchronous, active low) sets the parser idle, the accumulator and
// the attribute to zero, and empties the output buffer.
// ----------------------------------------------------------------------------
module ansi_sgr_attribute_parser_unit import sgr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_bold,
  output logic       out_underline,
  output logic       out_blink,
  output logic       out_inverse,
  output logic       out_fg_set,
  output logic [2:0] out_fg_color,
  output logic       out_bg_set,
  output logic [2:0] out_bg_color
);

  mode_t      mode_r, mode_nxt;
  logic [7:0] acc_r, acc_nxt;
  attr_t      attr_r, attr_nxt;
  logic       out_valid_r, out_valid_nxt;
  attr_t      out_attr_r, out_attr_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  attr_t      skid_attr_r, skid_attr_nxt;
  logic       in_xfer;
  logic       out_free;

  // Parser next state for the incoming byte.
  sgr_step u_step (
    .mode_i (mode_r),
    .acc_i  (acc_r),
    .attr_i (attr_r),
    .byte_i (in_byte_in),
    .mode_o (mode_nxt),
    .acc_o  (acc_nxt),
    .attr_o (attr_nxt)
  );

  assign in_stall = skid_valid_r;
  assign in_xfer  = in_valid && !skid_valid_r;
  // The result register can load when it is empty or its transfer completes.
  assign out_free = !out_valid_r || !out_stall;

  // Output buffer steering; each result is the attribute before its byte.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_attr_nxt   = out_attr_r;
    skid_valid_nxt = skid_valid_r;
    skid_attr_nxt  = skid_attr_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_attr_nxt   = skid_attr_r;
        skid_valid_nxt = 1'b0;
      end else if (in_xfer) begin
        out_valid_nxt = 1'b1;
        out_attr_nxt  = attr_r;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_xfer) begin
      skid_valid_nxt = 1'b1;
      skid_attr_nxt  = attr_r;
    end
  end

  // Control and parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      acc_r        <= '0;
      attr_r       <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (in_xfer) begin
        mode_r <= mode_nxt;
        acc_r  <= acc_nxt;
        attr_r <= attr_nxt;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    out_attr_r  <= out_attr_nxt;
    skid_attr_r <= skid_attr_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_bold      = out_attr_r.bold;
  assign out_underline = out_attr_r.underline;
  assign out_blink     = out_attr_r.blink;
  assign out_inverse   = out_attr_r.inverse;
  assign out_fg_set    = out_attr_r.fg_set;
  assign out_fg_color  = out_attr_r.fg_color;
  assign out_bg_set    = out_attr_r.bg_set;
  assign out_bg_color  = out_attr_r.bg_color;

endmodule
